// ===== hw/rtl/itmswo_pkg.sv =====
// ============================================================================
// itmswo_pkg
// shared types and constants for the itm swo trace packet decoder
// ============================================================================
`default_nettype none

package itmswo_pkg;

    typedef enum logic [1:0]
    {
        MODE_IDLE = 2'd0,
        MODE_SYNC = 2'd1,
        MODE_TS   = 2'd2,
        MODE_SWIT = 2'd3
    } mode_t;

    localparam logic [7:0] OVERFLOW_HDR = 8'h70;
    localparam logic [7:0] SYNC_BYTE    = 8'h00;
    localparam logic [3:0] TS_NIBBLE    = 4'h0;
    localparam logic [3:0] RSVD_NIBBLE  = 4'h4;
    localparam logic [1:0] SIZE_RSVD    = 2'd0;
    localparam logic [1:0] SIZE_WORD    = 2'd3;
    localparam logic [2:0] SYNC_ZEROS   = 3'd4;
    localparam logic [2:0] TS_MAX_BYTES = 3'd4;
    localparam logic [2:0] WORD_BYTES   = 3'd4;

    typedef struct packed
    {
        logic [31:0] payload;
        logic [2:0]  byte_count;
        logic [4:0]  port;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/itmswo_in_stage.sv =====
// ============================================================================
// itmswo_in_stage
// input register holding one trace byte until the parser takes it
// ============================================================================
`default_nettype none

module itmswo_in_stage
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    output logic            item_valid,
    output logic [7:0]      item_byte,
    input  wire logic       item_take
);
    import itmswo_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || item_take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/itmswo_parser.sv =====
// ============================================================================
// itmswo_parser
// packet framing state, channel count register and result register
// ============================================================================
`default_nettype none

module itmswo_parser
#(
    parameter int MAX_CHANNELS = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [5:0]       cfg_wr_data,
    input  wire logic             item_valid,
    input  wire logic [7:0]       item_byte,
    output logic                  item_take,
    output logic                  res_valid,
    output itmswo_pkg::result_t   res_data,
    input  wire logic             res_ready
);
    import itmswo_pkg::*;

    localparam logic [5:0] MAX_CH = 6'(MAX_CHANNELS);

    mode_t       mode_reg;
    mode_t       mode_next;
    logic [2:0]  seen_reg;
    logic [2:0]  seen_next;
    logic [2:0]  expected_reg;
    logic [2:0]  expected_next;
    logic [4:0]  pport_reg;
    logic [4:0]  pport_next;
    logic [31:0] shift_reg;
    logic [31:0] shift_next;
    logic [5:0]  chan_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_data_reg;

    logic [7:0]  b;
    logic [2:0]  seen_inc;
    logic [5:0]  limit;
    logic        emit;

    assign b         = item_byte;
    assign seen_inc  = seen_reg + 3'd1;
    assign limit     = (chan_reg > MAX_CH) ? MAX_CH : chan_reg;
    assign item_take = item_valid && (!out_valid_reg || res_ready);

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (item_take)
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (b == SYNC_BYTE)
                    begin
                        mode_next = MODE_SYNC;
                    end
                    else if (b == OVERFLOW_HDR)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (b[3:0] == TS_NIBBLE)
                    begin
                        if (b[7])
                        begin
                            mode_next = MODE_TS;
                        end
                    end
                    else if (b[3:0] != RSVD_NIBBLE && !b[2] && b[1:0] != SIZE_RSVD)
                    begin
                        mode_next = MODE_SWIT;
                    end
                end
                MODE_SYNC:
                begin
                    if (!(b == SYNC_BYTE && seen_reg < expected_reg))
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_TS:
                begin
                    if (!b[7] || seen_inc > TS_MAX_BYTES)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_SWIT:
                begin
                    if (seen_inc >= expected_reg)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        seen_next     = seen_reg;
        expected_next = expected_reg;
        pport_next    = pport_reg;
        shift_next    = shift_reg;
        emit          = 1'b0;
        if (item_take)
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (b == SYNC_BYTE)
                    begin
                        expected_next = SYNC_ZEROS;
                        seen_next     = 3'd0;
                    end
                    else if (b == OVERFLOW_HDR)
                    begin
                        seen_next = seen_reg;
                    end
                    else if (b[3:0] == TS_NIBBLE)
                    begin
                        if (b[7])
                        begin
                            seen_next = 3'd1;
                        end
                    end
                    else if (b[3:0] != RSVD_NIBBLE && !b[2] && b[1:0] != SIZE_RSVD)
                    begin
                        expected_next = (b[1:0] == SIZE_WORD) ? WORD_BYTES : {1'b0, b[1:0]};
                        pport_next    = b[7:3];
                        seen_next     = 3'd0;
                        shift_next    = 32'd0;
                    end
                end
                MODE_SYNC:
                begin
                    if (b == SYNC_BYTE && seen_reg < expected_reg)
                    begin
                        seen_next = seen_inc;
                    end
                end
                MODE_TS:
                begin
                    seen_next = seen_inc;
                end
                MODE_SWIT:
                begin
                    if (!seen_reg[2])
                    begin
                        shift_next = shift_reg | ({24'd0, b} << {seen_reg[1:0], 3'b000});
                    end
                    seen_next = seen_inc;
                    emit      = (seen_inc >= expected_reg) && ({1'b0, pport_reg} < limit);
                end
                default:
                begin
                    seen_next = seen_reg;
                end
            endcase
        end
    end

    assign out_valid_next = emit ? 1'b1 : (res_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            seen_reg      <= 3'd0;
            expected_reg  <= 3'd0;
            pport_reg     <= 5'd0;
            shift_reg     <= 32'd0;
            chan_reg      <= MAX_CH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            seen_reg      <= seen_next;
            expected_reg  <= expected_next;
            pport_reg     <= pport_next;
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                chan_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.port       <= pport_reg;
            out_data_reg.byte_count <= expected_reg;
            out_data_reg.payload    <= shift_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_emit_len: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (expected_reg == 3'd1 || expected_reg == 3'd2 || expected_reg == 3'd4))
        else $error("stimulus result with bad length");

    a_emit_port: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> ({1'b0, pport_reg} < limit))
        else $error("stimulus result on disabled port");

    a_no_take_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_ready) |-> !item_take)
        else $error("byte consumed while result stalled");

    a_sync_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_SYNC) |-> (seen_reg <= SYNC_ZEROS))
        else $error("sync zero count overrun");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/itm_swo_packet_decoder.sv =====
// ============================================================================
// itm_swo_packet_decoder
// itm trace byte stream to software stimulus packet decoder
// ============================================================================
// s_axis carries one raw trace byte per request in s_axis_tdata.
// m_axis carries one decoded stimulus packet per request:
//   port, byte_count and little-endian payload in m_axis_tdata.
// sync, timestamp, overflow, reserved and illegal bytes give no request.
// cfg_wr_en with cfg_wr_data sets the channel count; ports at or above
//   min(channel count, MAX_CHANNELS) are dropped. write only while idle.
// a byte is taken into an input register, then parsed into the result
//   register: the payload appears on m_axis from the result register once
//   the last byte of its packet has been parsed.
// throughput is one byte per cycle while no result is stalled on m_axis.
// a waiting result stalls the parser; the input register still takes one
//   more byte, then s_axis_tready drops until the result is taken.
// reset clears the parser to idle, the channel count to MAX_CHANNELS and
//   empties both registers.
// ============================================================================
`default_nettype none

module itm_swo_packet_decoder
#(
    parameter int MAX_CHANNELS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [5:0]  cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // trace_byte[7:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // port[4:0], byte_count[7:5], payload[39:8]
);
    import itmswo_pkg::*;

    logic       item_valid;
    logic [7:0] item_byte;
    logic       item_take;
    result_t    res_data;

    itmswo_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_take  (item_take)
    );

    itmswo_parser
    #(
        .MAX_CHANNELS (MAX_CHANNELS)
    )
    u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item_byte   (item_byte),
        .item_take   (item_take),
        .res_valid   (m_axis_tvalid),
        .res_data    (res_data),
        .res_ready   (m_axis_tready)
    );

    assign m_axis_tdata = {res_data.payload, res_data.byte_count, res_data.port};

endmodule

`default_nettype wire
